[rtl/unix_seconds_calendar_converter_unit_macros.svh]
// ----------------------------------------------------------------------------
// Unix seconds calendar converter - assertion macros
// Shared concurrent assertion forms, clocked on the rising edge, reset masked.
// ----------------------------------------------------------------------------
`ifndef UNIX_SECONDS_CALENDAR_CONVERTER_UNIT_MACROS_SVH
`define UNIX_SECONDS_CALENDAR_CONVERTER_UNIT_MACROS_SVH

// same-cycle implication
`define UCC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define UCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/ucc_pkg.sv]
// ----------------------------------------------------------------------------
// ucc_pkg
// Constants, command/status types and calendar helpers for the converter.
// ----------------------------------------------------------------------------
package ucc_pkg;

   localparam int DATA_W = 72;

   localparam logic [11:0] EPOCH_YEAR = 12'd1970;
   localparam logic [11:0] LAST_YEAR  = 12'd2105;
   localparam logic [11:0] SKIP_LEAP  = 12'd2100;

   localparam logic [16:0] DAY_SECS  = 17'd86400;
   localparam logic [16:0] HOUR_SECS = 17'd3600;
   localparam logic [16:0] MIN_SECS  = 17'd60;

   // reciprocals: day q = ((n >> 7) * R) >> 35, hour q = ((n >> 4) * R) >> 21,
   // minute q = ((n >> 2) * R) >> 14, exact over the operand ranges used
   localparam logic [25:0] RECIP_DAY  = 26'd50903317;
   localparam logic [25:0] RECIP_HOUR = 26'd9321;
   localparam logic [25:0] RECIP_MIN  = 26'd1093;

   localparam logic [31:0] YEAR_SECS_NORM = 32'd31536000;
   localparam logic [31:0] YEAR_SECS_LEAP = 32'd31622400;
   localparam logic [31:0] MON_SECS_28    = 32'd2419200;
   localparam logic [31:0] MON_SECS_29    = 32'd2505600;
   localparam logic [31:0] MON_SECS_30    = 32'd2592000;
   localparam logic [31:0] MON_SECS_31    = 32'd2678400;

   // datapath commands
   localparam logic [3:0] OP_NONE   = 4'd0;
   localparam logic [3:0] OP_LOAD   = 4'd1;
   localparam logic [3:0] OP_DIV    = 4'd2;
   localparam logic [3:0] OP_HOUR   = 4'd3;
   localparam logic [3:0] OP_MIN    = 4'd4;
   localparam logic [3:0] OP_TAIL   = 4'd5;
   localparam logic [3:0] OP_S_YEAR = 4'd6;
   localparam logic [3:0] OP_S_MON  = 4'd7;
   localparam logic [3:0] OP_C_INIT = 4'd8;
   localparam logic [3:0] OP_C_MON  = 4'd9;
   localparam logic [3:0] OP_C_YEAR = 4'd10;
   localparam logic [3:0] OP_OUT    = 4'd11;

   // divisor select
   localparam logic [1:0] DIV_DAY  = 2'd0;
   localparam logic [1:0] DIV_HOUR = 2'd1;
   localparam logic [1:0] DIV_MIN  = 2'd2;

   typedef struct packed {
      logic [3:0] op;
   } ucc_cmd_type;

   typedef struct packed {
      logic act;
      logic div_done;
      logic s_year_more;
      logic s_mon_more;
      logic c_mon_more;
      logic c_year_more;
   } ucc_stat_type;

   function automatic logic is_leap(input logic [11:0] y);
      return (y[1:0] == 2'b00) && (y != SKIP_LEAP);
   endfunction

   // idx is the zero-based month
   function automatic logic [4:0] month_days(input logic leap, input logic [3:0] idx);
      logic [4:0] d;
      case (idx)
         4'd1:                       d = leap ? 5'd29 : 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10:    d = 5'd30;
         default:                    d = 5'd31;
      endcase
      return d;
   endfunction

   function automatic logic [31:0] month_secs(input logic leap, input logic [3:0] idx);
      logic [31:0] s;
      case (month_days(leap, idx))
         5'd28:   s = MON_SECS_28;
         5'd29:   s = MON_SECS_29;
         5'd30:   s = MON_SECS_30;
         default: s = MON_SECS_31;
      endcase
      return s;
   endfunction

endpackage

[rtl/ucc_ctrl.sv]
// ----------------------------------------------------------------------------
// ucc_ctrl
// Sequencer: handshakes, step order and datapath commands.
// ----------------------------------------------------------------------------
`include "unix_seconds_calendar_converter_unit_macros.svh"

module ucc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  ucc_pkg::ucc_stat_type stat,
   output ucc_pkg::ucc_cmd_type  cmd
);
   import ucc_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SEL   = 4'd1;
   localparam logic [3:0] S_DDIV  = 4'd2;
   localparam logic [3:0] S_HDIV  = 4'd3;
   localparam logic [3:0] S_MDIV  = 4'd4;
   localparam logic [3:0] S_SYEAR = 4'd5;
   localparam logic [3:0] S_SMON  = 4'd6;
   localparam logic [3:0] S_CINIT = 4'd7;
   localparam logic [3:0] S_CMON  = 4'd8;
   localparam logic [3:0] S_CYEAR = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd.op       = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               state_in = S_SEL;
            end
         end
         S_SEL: begin
            state_in = stat.act ? S_DDIV : S_CINIT;
         end
         S_DDIV: begin
            if (!stat.div_done) begin
               cmd.op = OP_DIV;
            end else begin
               cmd.op   = OP_HOUR;
               state_in = S_HDIV;
            end
         end
         S_HDIV: begin
            if (!stat.div_done) begin
               cmd.op = OP_DIV;
            end else begin
               cmd.op   = OP_MIN;
               state_in = S_MDIV;
            end
         end
         S_MDIV: begin
            if (!stat.div_done) begin
               cmd.op = OP_DIV;
            end else begin
               cmd.op   = OP_TAIL;
               state_in = S_SYEAR;
            end
         end
         S_SYEAR: begin
            if (stat.s_year_more) begin
               cmd.op = OP_S_YEAR;
            end else begin
               state_in = S_SMON;
            end
         end
         S_SMON: begin
            if (stat.s_mon_more) begin
               cmd.op = OP_S_MON;
            end else begin
               state_in = S_DONE;
            end
         end
         S_CINIT: begin
            cmd.op   = OP_C_INIT;
            state_in = S_CMON;
         end
         S_CMON: begin
            if (stat.c_mon_more) begin
               cmd.op = OP_C_MON;
            end else begin
               state_in = S_CYEAR;
            end
         end
         S_CYEAR: begin
            if (stat.c_year_more) begin
               cmd.op = OP_C_YEAR;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.op       = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `UCC_ASSERT_NEXT(a_accept_to_sel, clock, reset, req_tvalid && req_tready, state_ff == S_SEL, "accepted request did not start dispatch")
   `UCC_ASSERT_NEXT(a_done_loads_rsp, clock, reset, state_ff == S_DONE && slot_free, rsp_valid_ff && state_ff == S_IDLE, "finished request not presented")
   `UCC_ASSERT_NEXT(a_div_holds, clock, reset, state_ff == S_DDIV && !stat.div_done, state_ff == S_DDIV, "day division left early")
   `UCC_ASSERT_NOW(a_busy_no_ready, clock, reset, state_ff != S_IDLE, !req_tready, "request taken while busy")

endmodule

[rtl/ucc_dp.sv]
// ----------------------------------------------------------------------------
// ucc_dp
// Datapath: request capture, reciprocal-multiply divider, year/month walk,
// seconds accumulator and result register.
// ----------------------------------------------------------------------------
module ucc_dp (
   input  logic                          clock,
   input  logic [ucc_pkg::DATA_W-1:0]    req_tdata,
   input  logic                          req_tuser,
   input  ucc_pkg::ucc_cmd_type          cmd,
   output ucc_pkg::ucc_stat_type         stat,
   output logic [ucc_pkg::DATA_W-1:0]    rsp_tdata
);
   import ucc_pkg::*;

   // captured request
   logic        act_ff, act_in;
   logic [11:0] r_year_ff, r_year_in;
   logic [3:0]  r_month_ff, r_month_in;
   logic [4:0]  r_day_ff, r_day_in;
   logic [4:0]  r_hour_ff, r_hour_in;
   logic [5:0]  r_minute_ff, r_minute_in;
   logic [5:0]  r_second_ff, r_second_in;

   // working registers
   logic [31:0] acc_ff, acc_in;
   logic        ok_ff, ok_in;
   logic [11:0] yr_ff, yr_in;
   logic [3:0]  mo_ff, mo_in;
   logic [15:0] days_ff, days_in;
   logic [31:0] num_ff, num_in;
   logic [15:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [1:0]  dsel_ff, dsel_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  minute_ff, minute_in;
   logic [5:0]  second_ff, second_in;
   logic [DATA_W-1:0] out_ff, out_in;

   // divider: quotient step, then remainder step
   logic [16:0] dv;
   logic [24:0] mul_a;
   logic [25:0] mul_b;
   logic [50:0] prod;
   logic [15:0] q_est;
   logic [31:0] q_back, r_full;

   // calendar checks
   logic        req_leap, ok_now, yr_leap;
   logic [4:0]  day_m1;
   logic [21:0] d_part;
   logic [16:0] h_part;
   logic [11:0] m_part;
   logic [31:0] time_sum;
   logic [8:0]  ylen;
   logic [4:0]  mlen;

   always_comb begin
      case (dsel_ff)
         DIV_DAY: begin
            dv    = DAY_SECS;
            mul_a = num_ff[31:7];
            mul_b = RECIP_DAY;
         end
         DIV_HOUR: begin
            dv    = HOUR_SECS;
            mul_a = {12'd0, num_ff[16:4]};
            mul_b = RECIP_HOUR;
         end
         default: begin
            dv    = MIN_SECS;
            mul_a = {15'd0, num_ff[11:2]};
            mul_b = RECIP_MIN;
         end
      endcase
   end

   assign prod = 51'(mul_a) * 51'(mul_b);

   always_comb begin
      case (dsel_ff)
         DIV_DAY:  q_est = prod[50:35];
         DIV_HOUR: q_est = prod[36:21];
         default:  q_est = prod[29:14];
      endcase
   end

   assign q_back = 32'(quo_ff) * 32'(dv);
   assign r_full = num_ff - q_back;

   assign req_leap = is_leap(r_year_ff);
   assign yr_leap  = is_leap(yr_ff);
   assign ok_now   = (r_second_ff < 6'd60) && (r_minute_ff < 6'd60) && (r_hour_ff < 5'd24)
                   && (r_month_ff >= 4'd1) && (r_month_ff <= 4'd12) && (r_day_ff >= 5'd1)
                   && (r_day_ff <= month_days(req_leap, r_month_ff - 4'd1))
                   && (r_year_ff >= EPOCH_YEAR) && (r_year_ff <= LAST_YEAR);

   assign day_m1   = r_day_ff - 5'd1;
   assign d_part   = 22'(day_m1) * 22'(DAY_SECS);
   assign h_part   = 17'(r_hour_ff) * HOUR_SECS;
   assign m_part   = 12'(r_minute_ff) * 12'(MIN_SECS);
   assign time_sum = 32'(d_part) + 32'(h_part) + 32'(m_part) + 32'(r_second_ff);

   assign ylen = yr_leap ? 9'd366 : 9'd365;
   assign mlen = month_days(yr_leap, mo_ff);

   assign stat.act         = act_ff;
   assign stat.div_done    = (cnt_ff == 2'd0);
   assign stat.s_year_more = days_ff >= 16'(ylen);
   assign stat.s_mon_more  = (mo_ff < 4'd11) && (days_ff >= 16'(mlen));
   assign stat.c_mon_more  = ok_ff && (mo_ff < r_month_ff);
   assign stat.c_year_more = ok_ff && (yr_ff < r_year_ff);

   assign rsp_tdata = out_ff;

   always_comb begin
      act_in      = act_ff;
      r_year_in   = r_year_ff;
      r_month_in  = r_month_ff;
      r_day_in    = r_day_ff;
      r_hour_in   = r_hour_ff;
      r_minute_in = r_minute_ff;
      r_second_in = r_second_ff;
      acc_in      = acc_ff;
      ok_in       = ok_ff;
      yr_in       = yr_ff;
      mo_in       = mo_ff;
      days_in     = days_ff;
      num_in      = num_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      cnt_in      = cnt_ff;
      dsel_in     = dsel_ff;
      hour_in     = hour_ff;
      minute_in   = minute_ff;
      second_in   = second_ff;
      out_in      = out_ff;
      unique case (cmd.op)
         OP_LOAD: begin
            act_in      = req_tuser;
            r_year_in   = req_tdata[43:32];
            r_month_in  = req_tdata[47:44];
            r_day_in    = req_tdata[52:48];
            r_hour_in   = req_tdata[57:53];
            r_minute_in = req_tdata[63:58];
            r_second_in = req_tdata[69:64];
            num_in      = req_tdata[31:0];
            cnt_in      = 2'd2;
            dsel_in     = DIV_DAY;
         end
         OP_DIV: begin
            if (cnt_ff[1]) begin
               quo_in = q_est;
            end else begin
               rem_in = r_full[16:0];
            end
            cnt_in = cnt_ff - 2'd1;
         end
         OP_HOUR: begin
            days_in = quo_ff;
            num_in  = 32'(rem_ff);
            cnt_in  = 2'd2;
            dsel_in = DIV_HOUR;
         end
         OP_MIN: begin
            hour_in = quo_ff[4:0];
            num_in  = 32'(rem_ff);
            cnt_in  = 2'd2;
            dsel_in = DIV_MIN;
         end
         OP_TAIL: begin
            minute_in = quo_ff[5:0];
            second_in = rem_ff[5:0];
            yr_in     = EPOCH_YEAR;
            mo_in     = 4'd0;
         end
         OP_S_YEAR: begin
            days_in = days_ff - 16'(ylen);
            yr_in   = yr_ff + 12'd1;
         end
         OP_S_MON: begin
            days_in = days_ff - 16'(mlen);
            mo_in   = mo_ff + 4'd1;
         end
         OP_C_INIT: begin
            ok_in  = ok_now;
            acc_in = ok_now ? time_sum : 32'd0;
            yr_in  = EPOCH_YEAR;
            mo_in  = 4'd1;
         end
         OP_C_MON: begin
            acc_in = acc_ff + month_secs(req_leap, mo_ff - 4'd1);
            mo_in  = mo_ff + 4'd1;
         end
         OP_C_YEAR: begin
            acc_in = acc_ff + (yr_leap ? YEAR_SECS_LEAP : YEAR_SECS_NORM);
            yr_in  = yr_ff + 12'd1;
         end
         OP_OUT: begin
            if (act_ff) begin
               out_in = {1'b0, 1'b1, second_ff, minute_ff, hour_ff,
                         days_ff[4:0] + 5'd1, mo_ff + 4'd1, yr_ff, 32'd0};
            end else begin
               out_in = {1'b0, ok_ff, 6'd0, 6'd0, 5'd0, 5'd0, 4'd0, 12'd0, acc_ff};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      r_year_ff   <= r_year_in;
      r_month_ff  <= r_month_in;
      r_day_ff    <= r_day_in;
      r_hour_ff   <= r_hour_in;
      r_minute_ff <= r_minute_in;
      r_second_ff <= r_second_in;
      acc_ff      <= acc_in;
      ok_ff       <= ok_in;
      yr_ff       <= yr_in;
      mo_ff       <= mo_in;
      days_ff     <= days_in;
      num_ff      <= num_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      dsel_ff     <= dsel_in;
      hour_ff     <= hour_in;
      minute_ff   <= minute_in;
      second_ff   <= second_in;
      out_ff      <= out_in;
   end

endmodule

[rtl/unix_seconds_calendar_converter_unit.sv]
// Calendar to seconds: after the field checks, a valid request adds one month's seconds per month
//   before the requested month, then one year's seconds per year from 1970 to the requested year.
// Seconds to calendar: three reciprocal-multiply divisions, then one year or month per cycle.
// One request at a time; the next is taken the cycle after a result enters the output
//   register, even while that result waits for rsp_tready.
// Synchronous active-high reset clears the sequencer and the response valid flag.
// ----------------------------------------------------------------------------
// unix_seconds_calendar_converter_unit
// Converts seconds since 1970 to calendar date and time, and back with checks.
// ----------------------------------------------------------------------------
module unix_seconds_calendar_converter_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // in_seconds, in_year, in_month, in_day, in_hour, in_minute, in_second, 2 pad bits
   input  logic [ucc_pkg::DATA_W-1:0] req_tdata,
   // action
   input  logic                       req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // out_seconds, out_year, out_month, out_day, out_hour, out_minute, out_second,
   // valid_res, 1 pad bit
   output logic [ucc_pkg::DATA_W-1:0] rsp_tdata
);
   import ucc_pkg::*;

   ucc_cmd_type  cmd;
   ucc_stat_type stat;

   ucc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ucc_dp u_dp (
      .clock     (clock),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata)
   );

endmodule

[sim/unix_seconds_calendar_converter_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unix_seconds_calendar_converter_unit_tb
// Drives seconds-to-calendar and calendar-to-seconds requests through the
// stream ports in random bursts against a stalling receiver. Each request's
// result is predicted in the bench and checked field by field, in order.
// ----------------------------------------------------------------------------
module unix_seconds_calendar_converter_unit_tb;
   import ucc_pkg::*;

   localparam logic ACT_TO_SECONDS  = 1'b0;
   localparam logic ACT_TO_CALENDAR = 1'b1;

   localparam int unsigned FIRST_YEAR   = 1970;
   localparam int unsigned FINAL_YEAR   = 2105;
   localparam int unsigned NO_LEAP_YEAR = 2100;
   localparam int unsigned DAY_SEC      = 86400;
   localparam int unsigned HOUR_SEC     = 3600;
   localparam int unsigned MIN_SEC      = 60;

   localparam int RANDOM_REQUESTS = 1200;
   localparam int IDLE_LIMIT      = 5000;
   localparam int DRAIN_CYCLES    = 250;
   localparam int PRINT_LIMIT     = 100;

   typedef enum logic [1:0] {
      READY_ALWAYS, READY_COIN, READY_PATTERN, READY_SPARSE
   } ready_mode_type;

   typedef struct packed {
      logic        action;
      logic [31:0] seconds;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } time_request_type;

   typedef struct packed {
      logic [31:0] seconds;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic        valid;
   } time_result_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata  = '0;
   logic              req_tuser  = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;

   time_request_type request_queue[$];
   time_result_type  awaited_results[$];
   time_request_type next_request;
   time_request_type request_on_bus;
   time_result_type  got_result;
   time_result_type  want_result;

   int             mismatch_count = 0;
   int             idle_cycles    = 0;
   int unsigned    burst_left     = 0;
   int unsigned    gap_left       = 0;
   ready_mode_type ready_mode     = READY_ALWAYS;
   int unsigned    mode_left      = 0;
   logic [15:0]    ready_mask     = 16'hFFFF;
   logic [3:0]     ready_phase    = '0;

   unix_seconds_calendar_converter_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ---- calendar arithmetic ----
   function automatic bit leap_year(input int unsigned y);
      return (y % 4 == 0) && (y != NO_LEAP_YEAR);
   endfunction

   function automatic int unsigned year_days(input int unsigned y);
      return leap_year(y) ? 366 : 365;
   endfunction

   // m is zero-based
   function automatic int unsigned days_in_month(input bit leap, input int unsigned m);
      case (m)
         1:           return leap ? 29 : 28;
         3, 5, 8, 10: return 30;
         default:     return 31;
      endcase
   endfunction

   function automatic time_result_type unix_calendar_convert(input time_request_type r);
      time_result_type res;
      int unsigned     total;
      int unsigned     days;
      int unsigned     tod;
      int unsigned     y;
      int unsigned     m;
      bit              ok;
      res = '0;
      if (r.action == ACT_TO_SECONDS) begin
         ok = (r.second < 60) && (r.minute < 60) && (r.hour < 24);
         ok = ok && (r.month >= 1) && (r.month <= 12) && (r.day >= 1);
         ok = ok && (r.day <= days_in_month(leap_year(32'(r.year)), 32'(r.month) - 1));
         ok = ok && (r.year >= FIRST_YEAR) && (r.year <= FINAL_YEAR);
         total = 0;
         if (ok) begin
            total = r.second + (r.day - 1) * DAY_SEC + r.hour * HOUR_SEC + r.minute * MIN_SEC;
            for (m = 1; m < r.month; m++)
               total += days_in_month(leap_year(32'(r.year)), m - 1) * DAY_SEC;
            for (y = FIRST_YEAR; y < r.year; y++)
               total += year_days(y) * DAY_SEC;
         end
         res.seconds = total;
         res.valid   = ok;
      end else begin
         tod  = r.seconds % DAY_SEC;
         days = r.seconds / DAY_SEC;
         y    = FIRST_YEAR;
         while (days >= year_days(y)) begin
            days -= year_days(y);
            y++;
         end
         m = 0;
         while (m < 11 && days >= days_in_month(leap_year(y), m)) begin
            days -= days_in_month(leap_year(y), m);
            m++;
         end
         res.year   = 12'(y);
         res.month  = 4'(m + 1);
         res.day    = 5'(days + 1);
         res.hour   = 5'(tod / HOUR_SEC);
         res.minute = 6'((tod % HOUR_SEC) / MIN_SEC);
         res.second = 6'(tod % MIN_SEC);
         res.valid  = 1'b1;
      end
      return res;
   endfunction

   // ---- packing ----
   function automatic logic [DATA_W-1:0] pack_request(input time_request_type r);
      return {2'b00, r.second, r.minute, r.hour, r.day, r.month, r.year, r.seconds};
   endfunction

   function automatic time_result_type unpack_result(input logic [DATA_W-1:0] d);
      time_result_type res;
      res.seconds = d[31:0];
      res.year    = d[43:32];
      res.month   = d[47:44];
      res.day     = d[52:48];
      res.hour    = d[57:53];
      res.minute  = d[63:58];
      res.second  = d[69:64];
      res.valid   = d[70];
      return res;
   endfunction

   // ---- stimulus ----
   function automatic time_request_type noise_request();
      time_request_type r;
      r.action  = 1'($urandom_range(0, 1));
      r.seconds = $urandom;
      r.year    = 12'($urandom);
      r.month   = 4'($urandom);
      r.day     = 5'($urandom);
      r.hour    = 5'($urandom);
      r.minute  = 6'($urandom);
      r.second  = 6'($urandom);
      return r;
   endfunction

   task automatic add_calendar(input int unsigned y, input int unsigned mo,
                               input int unsigned d, input int unsigned h,
                               input int unsigned mi, input int unsigned s);
      time_request_type r;
      r        = noise_request();
      r.action = ACT_TO_SECONDS;
      r.year   = 12'(y);
      r.month  = 4'(mo);
      r.day    = 5'(d);
      r.hour   = 5'(h);
      r.minute = 6'(mi);
      r.second = 6'(s);
      request_queue.push_back(r);
   endtask

   task automatic add_seconds(input logic [31:0] secs);
      time_request_type r;
      r         = noise_request();
      r.action  = ACT_TO_CALENDAR;
      r.seconds = secs;
      request_queue.push_back(r);
   endtask

   task automatic add_random_request();
      time_request_type r;
      int unsigned      pick;
      int unsigned      y;
      int unsigned      mo;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         if ($urandom_range(0, 7) == 0)
            add_seconds($urandom_range(32'hF000_0000, 32'hFFFF_FFFF));
         else
            add_seconds($urandom);
      end else if (pick < 92) begin
         y  = $urandom_range(FIRST_YEAR, FINAL_YEAR);
         mo = $urandom_range(1, 12);
         add_calendar(y, mo, $urandom_range(1, days_in_month(leap_year(y), mo - 1)),
                      $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
         if (pick >= 80) begin
            r = request_queue.pop_back();
            case ($urandom_range(0, 5))
               0: r.year   = 12'(($urandom_range(0, 1) != 0)
                                 ? $urandom_range(0, FIRST_YEAR - 1)
                                 : $urandom_range(FINAL_YEAR + 1, 4095));
               1: r.month  = 4'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(13, 15));
               2: r.day    = 5'(($urandom_range(0, 3) == 0) ? 0
                             : $urandom_range(days_in_month(leap_year(y), mo - 1) + 1, 31));
               3: r.hour   = 5'($urandom_range(24, 31));
               4: r.minute = 6'($urandom_range(60, 63));
               default: r.second = 6'($urandom_range(60, 63));
            endcase
            request_queue.push_back(r);
         end
      end else begin
         request_queue.push_back(noise_request());
      end
   endtask

   // ---- checking ----
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < PRINT_LIMIT)
         $display("%0t ns: %s got %0d expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   // ---- request driver ----
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left != 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (request_queue.size() != 0) begin
            next_request = request_queue.pop_front();
            req_tdata      <= pack_request(next_request);
            req_tuser      <= next_request.action;
            request_on_bus <= next_request;
            req_tvalid     <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
               case ($urandom_range(0, 9))
                  0:             gap_left <= $urandom_range(50, 250);
                  1, 2, 3, 4:    gap_left <= 0;
                  default:       gap_left <= $urandom_range(1, 8);
               endcase
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---- response receiver ----
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         ready_mode  <= READY_ALWAYS;
         mode_left   <= 0;
         ready_phase <= '0;
      end else begin
         ready_phase <= ready_phase + 4'd1;
         if (mode_left == 0) begin
            ready_mode <= ready_mode_type'($urandom_range(0, 3));
            mode_left  <= $urandom_range(20, 400);
            ready_mask <= 16'($urandom) | 16'h0001;
         end else begin
            mode_left <= mode_left - 1;
         end
         case (ready_mode)
            READY_ALWAYS:  rsp_tready <= 1'b1;
            READY_COIN:    rsp_tready <= 1'($urandom_range(0, 1));
            READY_PATTERN: rsp_tready <= ready_mask[ready_phase];
            default:       rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // ---- monitor ----
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            awaited_results.push_back(unix_calendar_convert(request_on_bus));
         if (rsp_tvalid && rsp_tready) begin
            got_result = unpack_result(rsp_tdata);
            if (awaited_results.size() == 0) begin
               report_mismatch("unexpected result, seconds", got_result.seconds, 32'd0);
            end else begin
               want_result = awaited_results.pop_front();
               check_field("out_seconds", got_result.seconds, want_result.seconds);
               check_field("out_year", 32'(got_result.year), 32'(want_result.year));
               check_field("out_month", 32'(got_result.month), 32'(want_result.month));
               check_field("out_day", 32'(got_result.day), 32'(want_result.day));
               check_field("out_hour", 32'(got_result.hour), 32'(want_result.hour));
               check_field("out_minute", 32'(got_result.minute), 32'(want_result.minute));
               check_field("out_second", 32'(got_result.second), 32'(want_result.second));
               check_field("valid_res", 32'(got_result.valid), 32'(want_result.valid));
            end
         end
      end
   end

   // ---- watchdog ----
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---- sequence ----
   initial begin
      // directed: epoch, extremes, leap rules, every out-of-range field
      add_seconds(32'd0);
      add_seconds(32'hFFFF_FFFF);
      add_seconds(32'd951782400);
      add_seconds(32'd4102444800);
      add_seconds(32'd4107542399);
      add_seconds(32'd4107542400);
      add_calendar(1970, 1, 1, 0, 0, 0);
      add_calendar(2105, 12, 31, 23, 59, 59);
      add_calendar(2106, 1, 1, 0, 0, 0);
      add_calendar(1969, 12, 31, 23, 59, 59);
      add_calendar(2000, 2, 29, 12, 0, 0);
      add_calendar(2100, 2, 29, 0, 0, 0);
      add_calendar(2100, 2, 28, 23, 59, 59);
      add_calendar(2001, 2, 29, 0, 0, 0);
      add_calendar(0, 0, 0, 0, 0, 0);
      add_calendar(2020, 13, 1, 0, 0, 0);
      add_calendar(4095, 15, 31, 31, 63, 63);
      add_calendar(2020, 5, 0, 0, 0, 0);
      add_calendar(2024, 4, 31, 0, 0, 0);
      add_calendar(2024, 6, 15, 24, 0, 0);
      add_calendar(2024, 6, 15, 0, 60, 0);
      add_calendar(2024, 6, 15, 0, 0, 60);
      add_calendar(2024, 12, 31, 23, 59, 59);
      repeat (RANDOM_REQUESTS) add_random_request();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (request_queue.size() != 0 || req_tvalid || awaited_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (awaited_results.size() != 0)
         report_mismatch("results never arrived", 32'd0, 32'(awaited_results.size()));

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/ucc_pkg.sv
rtl/ucc_ctrl.sv
rtl/ucc_dp.sv
rtl/unix_seconds_calendar_converter_unit.sv
sim/unix_seconds_calendar_converter_unit_tb.sv
